/* hdl/ldta_pkg.sv */
package ldta_pkg;

  // Width of every coordinate and of the polynomial register on the ports.
  localparam int COORD_W = 64;

  // Default field size m, in bits.
  localparam int FIELD_BITS_DEF = 64;

  // Bits of the multiplier operand consumed per cycle by the field multiplier while it is busy.
  localparam int DIGIT_BITS = 8;

  typedef logic [COORD_W-1:0] coord_t;

  // Reset value of the reduction polynomial, t^4 + t^3 + t + 1 below the implicit top term.
  localparam coord_t POLY_RESET = 64'd27;

endpackage

/* hdl/ldta_in_if.sv */
interface ldta_in_if;
  logic valid;
  logic ready;
  ldta_pkg::coord_t proj_x;
  ldta_pkg::coord_t proj_y;
  ldta_pkg::coord_t proj_z;

  modport source (output valid, output proj_x, output proj_y, output proj_z, input ready);
  modport sink (input valid, input proj_x, input proj_y, input proj_z, output ready);
endinterface

/* hdl/ldta_out_if.sv */
interface ldta_out_if;
  logic valid;
  logic ready;
  ldta_pkg::coord_t affine_x;
  ldta_pkg::coord_t affine_y;
  logic at_infinity;

  modport source (output valid, output affine_x, output affine_y, output at_infinity,
                  input ready);
  modport sink (input valid, input affine_x, input affine_y, input at_infinity,
                output ready);
endinterface

/* hdl/lopez_dahab_to_affine_top.sv */
// Channel   Direction  Payload                               Transaction when
// in_i      sink       proj_x, proj_y, proj_z                in_i.valid && in_i.ready
// out_o     source     affine_x, affine_y, at_infinity       out_o.valid && out_o.ready
// cfg       write      cfg_wdata_i (reduction_poly_low)      cfg_we_i
//
// A point with nonzero Z takes (2m + 2) field multiplications on the single
// digit-serial multiplier. Reset (rst_ni low, asynchronous) empties the block
// and loads the polynomial register with 27. A stalled output holds its
// transaction while the next input transaction is taken and computed.
module lopez_dahab_to_affine_top #(
  parameter int FIELD_BITS = ldta_pkg::FIELD_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  ldta_pkg::coord_t  cfg_wdata_i,
  ldta_in_if.sink           in_i,
  ldta_out_if.source        out_o
);
  import ldta_pkg::*;

  localparam int ICW = $clog2(FIELD_BITS);

  // Sequencer states. The inversion is Fermat's: r = z^(2^m - 2), built by
  // m - 1 rounds of square-then-multiply-by-z and one final square.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1; // r = r * r
  localparam logic [2:0] S_MZ   = 3'd2; // r = r * z
  localparam logic [2:0] S_FSQ  = 3'd3; // r = r * r, giving z^-1
  localparam logic [2:0] S_ZI2  = 3'd4; // r = z^-1 * z^-1
  localparam logic [2:0] S_MY   = 3'd5; // y = y * z^-2
  localparam logic [2:0] S_MX   = 3'd6; // x = x * z^-1
  localparam logic [2:0] S_HOLD = 3'd7; // result waits for the output register

  logic [2:0]            state_q, state_d;
  logic                  launched_q, launched_d;
  logic [ICW-1:0]        iter_q, iter_d;
  coord_t                poly_q;

  logic [FIELD_BITS-1:0] x_q, x_d;
  logic [FIELD_BITS-1:0] y_q, y_d;
  logic [FIELD_BITS-1:0] z_q, z_d;
  logic [FIELD_BITS-1:0] r_q, r_d;
  logic [FIELD_BITS-1:0] zi_q, zi_d;
  logic                  inf_q, inf_d;

  logic                  out_valid_q, out_valid_d;
  coord_t                out_x_q, out_y_q;
  logic                  out_inf_q;
  logic                  out_load;

  logic                  mul_start;
  logic [FIELD_BITS-1:0] mul_a, mul_b;
  logic                  mul_done;
  logic [FIELD_BITS-1:0] mul_prod;
  logic                  in_fire;

  // Bits at and above the field size are dropped on the way in.
  logic [FIELD_BITS-1:0] in_x, in_y, in_z;
  assign in_x = in_i.proj_x[FIELD_BITS-1:0];
  assign in_y = in_i.proj_y[FIELD_BITS-1:0];
  assign in_z = in_i.proj_z[FIELD_BITS-1:0];

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  ldta_gfmul #(
    .FIELD_BITS (FIELD_BITS)
  ) u_gfmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .poly_i (poly_q[FIELD_BITS-1:0]),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  // Operand selection only matters in the cycle the multiplier is started.
  always_comb begin
    mul_a = r_q;
    mul_b = r_q;
    case (state_q)
      S_MZ: begin
        mul_b = z_q;
      end
      S_MY: begin
        mul_a = y_q;
      end
      S_MX: begin
        mul_a = x_q;
        mul_b = zi_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    launched_d = launched_q;
    iter_d     = iter_q;
    x_d        = x_q;
    y_d        = y_q;
    z_d        = z_q;
    r_d        = r_q;
    zi_d       = zi_q;
    inf_d      = inf_q;
    mul_start  = 1'b0;
    out_load   = 1'b0;

    // Every multiply state starts the unit once, then waits for its done pulse.
    if (state_q != S_IDLE && state_q != S_HOLD && !launched_q) begin
      mul_start  = 1'b1;
      launched_d = 1'b1;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          x_d    = in_x;
          y_d    = in_y;
          z_d    = in_z;
          r_d    = FIELD_BITS'(1);
          iter_d = ICW'(FIELD_BITS - 2);
          if (in_z == '0) begin
            inf_d   = 1'b1;
            x_d     = '0;
            y_d     = '0;
            state_d = S_HOLD;
          end else begin
            inf_d   = 1'b0;
            state_d = S_SQ;
          end
        end
      end
      S_SQ: begin
        if (mul_done) begin
          r_d        = mul_prod;
          launched_d = 1'b0;
          state_d    = S_MZ;
        end
      end
      S_MZ: begin
        if (mul_done) begin
          r_d        = mul_prod;
          launched_d = 1'b0;
          if (iter_q == '0) begin
            state_d = S_FSQ;
          end else begin
            iter_d  = iter_q - 1'b1;
            state_d = S_SQ;
          end
        end
      end
      S_FSQ: begin
        if (mul_done) begin
          r_d        = mul_prod;
          zi_d       = mul_prod;
          launched_d = 1'b0;
          state_d    = S_ZI2;
        end
      end
      S_ZI2: begin
        if (mul_done) begin
          r_d        = mul_prod;
          launched_d = 1'b0;
          state_d    = S_MY;
        end
      end
      S_MY: begin
        if (mul_done) begin
          y_d        = mul_prod;
          launched_d = 1'b0;
          state_d    = S_MX;
        end
      end
      S_MX: begin
        if (mul_done) begin
          x_d        = mul_prod;
          launched_d = 1'b0;
          state_d    = S_HOLD;
        end
      end
      S_HOLD: begin
        // Move the result into the output register once it is free.
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_o.ready) || out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      launched_q  <= 1'b0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
      poly_q      <= POLY_RESET;
    end else begin
      state_q     <= state_d;
      launched_q  <= launched_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        poly_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    r_q   <= r_d;
    zi_q  <= zi_d;
    inf_q <= inf_d;
    if (out_load) begin
      out_x_q   <= COORD_W'(x_q);
      out_y_q   <= COORD_W'(y_q);
      out_inf_q <= inf_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.affine_x    = out_x_q;
  assign out_o.affine_y    = out_y_q;
  assign out_o.at_infinity = out_inf_q;

endmodule

/* hdl/ldta_gfmul.sv */
module ldta_gfmul #(
  parameter int FIELD_BITS = ldta_pkg::FIELD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [FIELD_BITS-1:0] a_i,
  input  logic [FIELD_BITS-1:0] b_i,
  input  logic [FIELD_BITS-1:0] poly_i,
  output logic                  done_o,
  output logic [FIELD_BITS-1:0] prod_o
);
  import ldta_pkg::*;

  localparam int NDIG = (FIELD_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int BW   = NDIG * DIGIT_BITS;
  localparam int CW   = (NDIG > 1) ? $clog2(NDIG) : 1;

  logic [FIELD_BITS-1:0] a_q;
  logic [BW-1:0]         b_q;
  logic [FIELD_BITS-1:0] r_q, r_d;
  logic [CW-1:0]         cnt_q;
  logic                  busy_q;
  logic                  done_q;
  logic                  carry;

  // Most significant digit first: shift the partial product up one bit,
  // fold the overflow back with the polynomial, then add a if the bit is set.
  always_comb begin
    r_d   = r_q;
    carry = 1'b0;
    for (int j = DIGIT_BITS - 1; j >= 0; j--) begin
      carry = r_d[FIELD_BITS-1];
      r_d   = {r_d[FIELD_BITS-2:0], 1'b0};
      if (carry) begin
        r_d = r_d ^ poly_i;
      end
      if (b_q[BW-DIGIT_BITS+j]) begin
        r_d = r_d ^ a_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NDIG - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= BW'(b_i);
      r_q <= '0;
    end else if (busy_q) begin
      b_q <= b_q << DIGIT_BITS;
      r_q <= r_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = r_q;

endmodule

/* test/tb_lopez_dahab_to_affine_top.sv */
`timescale 1ns / 100ps

module tb_lopez_dahab_to_affine_top;
  import ldta_pkg::*;

  // The block is built at its default field size; the predictor follows it.
  localparam int FIELD_BITS = FIELD_BITS_DEF;
  localparam coord_t FIELD_MASK = {COORD_W{1'b1}} >> (COORD_W - FIELD_BITS);
  localparam coord_t ALL_ONES = {COORD_W{1'b1}};
  localparam coord_t TOP_BIT = coord_t'(1) << (FIELD_BITS - 1);
  localparam int CLK_PERIOD = 4;

  // Time allowed for one finite point, covering its 2m + 2 digit-serial
  // multiplications and their sequencing.
  localparam int POINT_CYCLES = (2 * FIELD_BITS + 2) * ((FIELD_BITS + 7) / 8 + 2) + 3;

  // A correct run takes roughly 1250 points, each waiting out one full
  // conversion plus the longest sender gap and receiver stall. The limit is
  // that figure taken four times over.
  localparam int POINT_COUNT = 1250;
  localparam longint CYCLE_LIMIT = 4 * longint'(POINT_COUNT) * (POINT_CYCLES + 30);

  localparam int MAX_REPORTS = 10;

  // One affine result as it leaves the block.
  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   inf;
  } affine_pt_t;

  logic   clk;
  logic   rst_n;
  logic   cfg_we;
  coord_t cfg_wdata;

  ldta_in_if  u_in ();
  ldta_out_if u_out ();

  lopez_dahab_to_affine_top #(
    .FIELD_BITS(FIELD_BITS)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (u_in),
    .out_o      (u_out)
  );

  // Predictor state: the testbench's own copy of the reduction polynomial.
  coord_t field_poly;

  // Affine points predicted for accepted transactions, oldest first.
  affine_pt_t pending_affine[$];

  int     error_count;
  longint cycle_count;

  // While set, neither side inserts idle cycles, so back-to-back transactions
  // are exercised on both channels.
  bit no_idle;

  // Every input is known from time zero; reset is low from the start.
  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    u_in.valid  = 1'b0;
    u_in.proj_x = '0;
    u_in.proj_y = '0;
    u_in.proj_z = '0;
    u_out.ready = 1'b0;
    field_poly  = POLY_RESET;
    error_count = 0;
    cycle_count = 0;
    no_idle     = 1'b0;
  end

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_affine.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Product of two field elements modulo t^m + field_poly. The operand b is
  // scanned from its top bit, the running sum being doubled and reduced at
  // each step, which is the plain shift-and-add multiplication.
  function automatic coord_t gf2m_mul(coord_t a, coord_t b);
    coord_t poly;
    coord_t acc;
    logic   carry;
    poly = field_poly & FIELD_MASK;
    acc  = '0;
    a    = a & FIELD_MASK;
    b    = b & FIELD_MASK;
    for (int i = FIELD_BITS - 1; i >= 0; i--) begin
      carry = acc[FIELD_BITS-1];
      acc   = (acc << 1) & FIELD_MASK;
      if (carry) acc = acc ^ poly;
      if (b[i]) acc = acc ^ a;
    end
    return acc;
  endfunction

  // Inverse by Fermat: z^(2^m - 2). The exponent is m - 1 ones and then a
  // zero, so it is square-and-multiply m - 1 times and a last squaring. For a
  // reducible polynomial this is not a true inverse, but the block answers
  // with the same power and raises no flag.
  function automatic coord_t gf2m_inv(coord_t z);
    coord_t acc;
    acc = coord_t'(1);
    for (int i = 0; i < FIELD_BITS - 1; i++) begin
      acc = gf2m_mul(gf2m_mul(acc, acc), z);
    end
    return gf2m_mul(acc, acc);
  endfunction

  // Affine form of one projective point. Bits above the field size are
  // dropped before anything else, and the infinity test is made on the
  // masked Z.
  function automatic affine_pt_t to_affine(coord_t px, coord_t py, coord_t pz);
    affine_pt_t pt;
    coord_t     z_inv;
    px = px & FIELD_MASK;
    py = py & FIELD_MASK;
    pz = pz & FIELD_MASK;
    if (pz == '0) begin
      pt.x   = '0;
      pt.y   = '0;
      pt.inf = 1'b1;
    end else begin
      z_inv  = gf2m_inv(pz);
      pt.x   = gf2m_mul(px, z_inv);
      pt.y   = gf2m_mul(py, gf2m_mul(z_inv, z_inv));
      pt.inf = 1'b0;
    end
    return pt;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic int draw_idle();
    return no_idle ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic coord_t rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly dense random elements, with some small values, all-ones words and
  // single set bits mixed in to hit the edges of the reduction.
  function automatic coord_t rand_coord();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 16) return rand_word();
    if (pick < 18) return coord_t'($urandom_range(0, 255));
    if (pick < 19) return ALL_ONES;
    return coord_t'(1) << $urandom_range(0, COORD_W - 1);
  endfunction

  // Sends one projective point. The sender idles for a random number of
  // cycles first, then holds the transaction until the block takes it. The
  // prediction is queued at the edge where the transaction is accepted.
  task automatic send_point(coord_t px, coord_t py, coord_t pz);
    affine_pt_t pt;
    int         gap;
    pt  = to_affine(px, py, pz);
    gap = draw_idle();
    @(negedge clk);
    if (gap > 0) begin
      u_in.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    u_in.valid  <= 1'b1;
    u_in.proj_x <= px;
    u_in.proj_y <= py;
    u_in.proj_z <= pz;
    do @(posedge clk); while (!u_in.ready);
    pending_affine.push_back(pt);
  endtask

  task automatic send_random_point();
    coord_t pz;
    pz = ($urandom_range(0, 19) == 0) ? coord_t'(0) : rand_coord();
    send_point(rand_coord(), rand_coord(), pz);
  endtask

  // Stops sending and waits until every predicted result has come back.
  task automatic drain_results();
    @(negedge clk);
    u_in.valid <= 1'b0;
    while (pending_affine.size() != 0) @(posedge clk);
  endtask

  // The polynomial is only written with the block idle. Every point yields a
  // result, so once the queue is empty nothing is left in flight; spare
  // cycles are still let pass before the write.
  task automatic write_field_poly(coord_t value);
    drain_results();
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we     <= 1'b0;
    field_poly  = value;
  endtask

  // ---------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(string what, coord_t want, coord_t got);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("Mismatch on %s at cycle %0d: expected %h, got %h",
               what, cycle_count, want, got);
    end
  endtask

  // Receiver: stalls a random number of cycles before each transaction and
  // compares every accepted result with the oldest prediction.
  initial begin : result_monitor
    int         stall;
    affine_pt_t want;
    @(posedge rst_n);
    forever begin
      stall = draw_idle();
      @(negedge clk);
      if (stall > 0) begin
        u_out.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      u_out.ready <= 1'b1;
      do @(posedge clk); while (!u_out.valid);
      if (pending_affine.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("Unexpected result at cycle %0d: x %h, y %h, at_infinity %b",
                   cycle_count, u_out.affine_x, u_out.affine_y, u_out.at_infinity);
        end
      end else begin
        want = pending_affine.pop_front();
        if (u_out.affine_x !== want.x) report_mismatch("affine_x", want.x, u_out.affine_x);
        if (u_out.affine_y !== want.y) report_mismatch("affine_y", want.y, u_out.affine_y);
        if (u_out.at_infinity !== want.inf) begin
          report_mismatch("at_infinity", coord_t'(want.inf), coord_t'(u_out.at_infinity));
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Points at the edges of the fields, run with the polynomial left at its
  // reset value, which also checks that value. The point at infinity shows
  // up with zero and with nonzero X and Y.
  task automatic test_directed_points();
    send_point('0, '0, coord_t'(1));
    send_point(coord_t'(1), coord_t'(1), coord_t'(1));
    send_point(ALL_ONES, ALL_ONES, coord_t'(1));
    send_point(ALL_ONES, ALL_ONES, '0);
    send_point('0, '0, '0);
    send_point(coord_t'(1), ALL_ONES, ALL_ONES);
    send_point(TOP_BIT, TOP_BIT, TOP_BIT);
    send_point(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, coord_t'(2));
    send_point(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555);
    send_point(ALL_ONES, '0, TOP_BIT | coord_t'(1));
    send_point(rand_word(), rand_word(), rand_word());
    send_point(rand_word(), rand_word(), '0);
  endtask

  // The smallest and the largest polynomial values. Both give reducible
  // polynomials, where the block still answers with its power of Z.
  task automatic test_poly_extremes();
    coord_t polys[2];
    polys[0] = coord_t'(1);
    polys[1] = ALL_ONES;
    foreach (polys[p]) begin
      write_field_poly(polys[p]);
      send_point(ALL_ONES, ALL_ONES, coord_t'(1));
      send_point(ALL_ONES, ALL_ONES, '0);
      send_point(TOP_BIT, coord_t'(1), ALL_ONES);
      send_point(coord_t'(1), TOP_BIT, TOP_BIT);
      repeat (56) send_random_point();
    end
  endtask

  // The bulk of the run on an irreducible polynomial, with stretches of
  // back-to-back traffic and a full drain every hundred points.
  task automatic test_random_points();
    write_field_poly(POLY_RESET);
    for (int i = 0; i < 700; i++) begin
      if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (i % 100 == 99) drain_results();
      send_random_point();
    end
    no_idle = 1'b0;
  endtask

  // A handful of other polynomials, random and single-bit, ending back on
  // the reset value.
  task automatic test_random_polys();
    coord_t polys[4];
    polys[0] = rand_word();
    polys[1] = TOP_BIT;
    polys[2] = rand_word() | coord_t'(1);
    polys[3] = POLY_RESET;
    foreach (polys[p]) begin
      write_field_poly(polys[p]);
      repeat (100) send_random_point();
    end
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_points();
    test_poly_extremes();
    test_random_points();
    test_random_polys();

    // Let any stray result surface before the verdict.
    drain_results();
    repeat (POINT_CYCLES) @(posedge clk);
    error_count += pending_affine.size();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
